### src/rmf_pkg.sv
// ----------------------------------------------------------------------------
// rmf_pkg
// shared types, register codes and the median-of-nine network
// ----------------------------------------------------------------------------
package rmf_pkg;

  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;

  // configuration port
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_W-1:0]     CFG_SIZE_RESET   = CFG_W'(512);

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // per-item control decided at the front
  typedef struct packed {
    logic emit;
    logic last;
    logic left_edge;
    logic right_edge;
    logic top_edge;
    logic bottom_edge;
  } item_flags_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  localparam int WINDOW_SIZE = 9;
  typedef logic [WINDOW_SIZE-1:0][7:0] med_vec_t;

  // compare-exchange network for the median of nine, split in three stages
  localparam int NUM_OPS     = 19;
  localparam int STAGE1_LAST = 8;
  localparam int STAGE2_LAST = 15;
  localparam int STAGE3_LAST = 18;
  localparam logic [3:0] MED_INDEX = 4'd4;

  localparam logic [3:0] OP_A [NUM_OPS] = '{
    4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd0,
    4'd5, 4'd4, 4'd3, 4'd1, 4'd2, 4'd4, 4'd4, 4'd6, 4'd4
  };
  localparam logic [3:0] OP_B [NUM_OPS] = '{
    4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8, 4'd3,
    4'd8, 4'd7, 4'd6, 4'd4, 4'd5, 4'd7, 4'd2, 4'd4, 4'd2
  };

  // apply compare-exchange ops lo..hi in order, smaller value to OP_A
  function automatic med_vec_t sort_ops(input med_vec_t v, input int lo, input int hi);
    med_vec_t   p;
    logic [7:0] t;
    p = v;
    for (int k = 0; k < NUM_OPS; k++) begin
      if (k >= lo && k <= hi && p[OP_A[k]] > p[OP_B[k]]) begin
        t          = p[OP_A[k]];
        p[OP_A[k]] = p[OP_B[k]];
        p[OP_B[k]] = t;
      end
    end
    return p;
  endfunction

endpackage

### src/rmf_stream_if.sv
// ----------------------------------------------------------------------------
// rmf stream interfaces
// pixel input channel and median result channel, valid/ready
// ----------------------------------------------------------------------------
interface rmf_pixel_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, output mode, output red_in, output green_in,
                  output blue_in, input ready);
  modport sink   (input valid, input mode, input red_in, input green_in,
                  input blue_in, output ready);
endinterface

interface rmf_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_median;
  logic [7:0] green_median;
  logic [7:0] blue_median;
  logic       frame_end;

  modport source (output valid, output red_median, output green_median,
                  output blue_median, output frame_end, input ready);
  modport sink   (input valid, input red_median, input green_median,
                  input blue_median, input frame_end, output ready);
endinterface

### src/rgb_median_filter_3x3.sv
// ----------------------------------------------------------------------------
// rgb_median_filter_3x3
// streaming 3x3 median filter on rgb pixels, each channel on its own
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  pixel     in   valid/ready        mode, red_in, green_in, blue_in
//  result    out  valid/ready        red_median, green_median, blue_median,
//                                    frame_end
//  cfg       in   cfg_we (no wait)   cfg_index, cfg_wdata
//
//  one item per clock sustained while the result side is ready; a result passes
//  through the queue, line store read, window, two sorting stages and the last
//  sorting stage into the output register
//  pixel.ready drops only when the 4-entry queue is full
//  a stall on the result side freezes the back pipeline; the front keeps
//  taking items until the queue fills
//  synchronous reset clears counters, window, queue and valids; line
//  stores need no clearing pass
// ----------------------------------------------------------------------------
module rgb_median_filter_3x3
  import rmf_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  rmf_pixel_if.sink            pixel,
  rmf_result_if.source         result
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int QW = CW + $bits(item_flags_t) + $bits(pixel_t);

  // front to queue
  logic          push;
  logic [CW-1:0] push_col;
  item_flags_t   push_flags;
  pixel_t        push_pix;

  // queue to back
  logic          pop;
  logic [QW-1:0] q_wdata;
  logic [QW-1:0] q_rdata;
  queue_status_t q_status;
  logic [CW-1:0] q_col;
  item_flags_t   q_flags;
  pixel_t        q_pix;

  // front: size registers, position counters, edge and emit decisions
  rmf_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .pixel      (pixel),
    .q_status   (q_status),
    .push       (push),
    .push_col   (push_col),
    .push_flags (push_flags),
    .push_pix   (push_pix)
  );

  // classified items wait here while the back is stalled
  assign q_wdata = {push_col, push_flags, push_pix};

  rmf_queue #(
    .DATA_W (QW),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  (q_wdata),
    .pop    (pop),
    .rdata  (q_rdata),
    .status (q_status)
  );

  assign {q_col, q_flags, q_pix} = q_rdata;

  // back: line stores, window and median pipeline
  rmf_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (!q_status.empty),
    .q_col   (q_col),
    .q_flags (q_flags),
    .q_pix   (q_pix),
    .pop     (pop),
    .result  (result)
  );

  // a full queue that is popped has room on the next cycle
  a_queue_drain: assert property (@(posedge clk) disable iff (rst)
    q_status.full && pop && !push |=> !q_status.full)
    else $error("queue stays full after pop");

  // the back takes a waiting item whenever its output can move
  a_back_pop: assert property (@(posedge clk) disable iff (rst)
    !q_status.empty && (!result.valid || result.ready) |-> pop)
    else $error("back pipeline idles with a queued item");

  // reset leaves no result and no queued item
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result.valid && q_status.empty)
    else $error("state survives reset");

endmodule

### src/rmf_front.sv
// ----------------------------------------------------------------------------
// rmf_front
// size registers, raster position counters and per-item classification
// ----------------------------------------------------------------------------
module rmf_front
  import rmf_pkg::*;
#(
  parameter int  MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int  MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int CW         = $clog2(MAX_WIDTH)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  rmf_pixel_if.sink            pixel,
  input  queue_status_t        q_status,
  output logic                 push,
  output logic [CW-1:0]        push_col,
  output item_flags_t          push_flags,
  output pixel_t               push_pix
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 4);
  localparam int WX = (CFG_W > WW) ? CFG_W : WW;
  localparam int HX = (CFG_W > HW) ? CFG_W : HW;

  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [CW-1:0]    col;
  logic [RW-1:0]    row;
  logic [CW-1:0]    col_next;
  logic [RW-1:0]    row_next;

  logic [WX-1:0] w_raw;
  logic [HX-1:0] h_raw;
  logic [WW-1:0] w_size;
  logic [HW-1:0] h_size;
  logic [RW-1:0] h_ext;

  logic [CW-1:0] c1;
  logic [RW-1:0] r1;
  logic [RW-1:0] rr;
  logic          r_ok;
  logic [WW-1:0] cn;
  logic          accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_SIZE_RESET;
      image_height <= CFG_SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_wdata;
        REG_IMAGE_HEIGHT: image_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sizes saturated to 1..max
  assign w_raw = WX'(image_width);
  assign h_raw = HX'(image_height);

  always_comb begin
    if (w_raw == '0) begin
      w_size = WW'(1);
    end else if (w_raw > WX'(MAX_WIDTH)) begin
      w_size = WW'(MAX_WIDTH);
    end else begin
      w_size = WW'(w_raw);
    end
    if (h_raw == '0) begin
      h_size = HW'(1);
    end else if (h_raw > HX'(MAX_HEIGHT)) begin
      h_size = HW'(MAX_HEIGHT);
    end else begin
      h_size = HW'(h_raw);
    end
  end

  assign h_ext = RW'(h_size);

  always_comb begin
    c1 = col;
    r1 = row;
    // a size change can leave the counters outside the frame
    if (WW'(col) >= w_size) begin
      c1 = '0;
      r1 = row + RW'(1);
    end
    if (r1 > h_ext + RW'(1)) begin
      r1 = '0;
      c1 = '0;
    end

    // row of the window center
    if (c1 == '0) begin
      r_ok = r1 >= RW'(2);
      rr   = r1 - RW'(2);
    end else begin
      r_ok = r1 != '0;
      rr   = r1 - RW'(1);
    end

    push_flags.emit        = r_ok && (rr < h_ext);
    push_flags.right_edge  = (c1 == '0);
    push_flags.left_edge   = (c1 == '0) ? (w_size == WW'(1)) : (c1 == CW'(1));
    push_flags.top_edge    = (rr == '0);
    push_flags.bottom_edge = (rr == h_ext - RW'(1));
    push_flags.last        = push_flags.emit && push_flags.bottom_edge &&
                             push_flags.right_edge;

    cn = WW'(c1) + WW'(1);
    if (cn >= w_size) begin
      col_next = '0;
      row_next = r1 + RW'(1);
    end else begin
      col_next = CW'(cn);
      row_next = r1;
    end
    if (push_flags.last) begin
      col_next = '0;
      row_next = '0;
    end
  end

  always_comb begin
    if (!pixel.mode && (r1 < h_ext)) begin
      push_pix = '{red: pixel.red_in, green: pixel.green_in, blue: pixel.blue_in};
    end else begin
      push_pix = '0;
    end
  end

  assign pixel.ready = !q_status.full;
  assign accept      = pixel.valid && pixel.ready;
  assign push        = accept;
  assign push_col    = c1;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

endmodule

### src/rmf_queue.sv
// ----------------------------------------------------------------------------
// rmf_queue
// small register queue between front and back
// ----------------------------------------------------------------------------
module rmf_queue
  import rmf_pkg::*;
#(
  parameter int DATA_W = 8,
  parameter int DEPTH  = QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] wdata,
  input  logic              pop,
  output logic [DATA_W-1:0] rdata,
  output queue_status_t     status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [NW-1:0]     count;

  assign status.full  = (count == NW'(DEPTH));
  assign status.empty = (count == '0);
  assign rdata        = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

endmodule

### src/rmf_back.sv
// ----------------------------------------------------------------------------
// rmf_back
// line stores, 3x3 window and pipelined median per channel
// ----------------------------------------------------------------------------
module rmf_back
  import rmf_pkg::*;
#(
  parameter int  MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int CW        = $clog2(MAX_WIDTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  logic [CW-1:0] q_col,
  input  item_flags_t   q_flags,
  input  pixel_t        q_pix,
  output logic          pop,
  rmf_result_if.source  result
);

  pixel_t upper_line_store  [MAX_WIDTH];
  pixel_t middle_line_store [MAX_WIDTH];

  logic          en;
  logic          wr_en;

  logic          s1_valid;
  logic [CW-1:0] s1_col;
  item_flags_t   s1_flags;
  pixel_t        s1_pix;
  pixel_t        rd_top;
  pixel_t        rd_mid;
  logic          byp;
  pixel_t        byp_top;
  pixel_t        byp_mid;
  pixel_t        top_eff;
  pixel_t        mid_eff;

  pixel_t        win   [3][3];
  pixel_t        win_sh[3][3];
  pixel_t        win_m [3][3];
  med_vec_t      win_vec[3];

  logic          s2_valid;
  logic          s2_last;
  med_vec_t      s2_vec[3];
  logic          m1_valid;
  logic          m1_last;
  med_vec_t      m1_vec[3];
  logic          m2_valid;
  logic          m2_last;
  med_vec_t      m2_vec[3];
  med_vec_t      m3_vec[3];

  logic          out_valid;
  logic          out_last;
  logic [7:0]    out_med[3];

  assign en    = !out_valid || result.ready;
  assign pop   = en && q_valid;
  assign wr_en = en && s1_valid;

  // read at the new item's column while the item ahead writes its own column
  always_ff @(posedge clk) begin
    if (pop) begin
      rd_top <= upper_line_store[q_col];
    end
    if (wr_en) begin
      upper_line_store[s1_col] <= mid_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_mid <= middle_line_store[q_col];
    end
    if (wr_en) begin
      middle_line_store[s1_col] <= s1_pix;
    end
  end

  // same column written and read at one edge (one-pixel rows)
  always_ff @(posedge clk) begin
    if (pop) begin
      byp     <= wr_en && (s1_col == q_col);
      byp_top <= mid_eff;
      byp_mid <= s1_pix;
    end
  end

  assign top_eff = byp ? byp_top : rd_top;
  assign mid_eff = byp ? byp_mid : rd_mid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_col   <= q_col;
      s1_flags <= q_flags;
      s1_pix   <= q_pix;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_sh[i][0] = win[i][1];
      win_sh[i][1] = win[i][2];
    end
    win_sh[0][2] = top_eff;
    win_sh[1][2] = mid_eff;
    win_sh[2][2] = s1_pix;
  end

  // neighbors outside the image are zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        win_m[i][j] = win_sh[i][j];
        if ((s1_flags.left_edge && j == 0) || (s1_flags.right_edge && j == 2) ||
            (s1_flags.top_edge && i == 0) || (s1_flags.bottom_edge && i == 2)) begin
          win_m[i][j] = '0;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        win_vec[0][4'(i * 3 + j)] = win_m[i][j].red;
        win_vec[1][4'(i * 3 + j)] = win_m[i][j].green;
        win_vec[2][4'(i * 3 + j)] = win_m[i][j].blue;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
    end else if (wr_en) begin
      win <= win_sh;
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    assign m3_vec[ch] = sort_ops(m2_vec[ch], STAGE2_LAST + 1, STAGE3_LAST);

    always_ff @(posedge clk) begin
      if (en) begin
        s2_vec[ch]  <= win_vec[ch];
        m1_vec[ch]  <= sort_ops(s2_vec[ch], 0, STAGE1_LAST);
        m2_vec[ch]  <= sort_ops(m1_vec[ch], STAGE1_LAST + 1, STAGE2_LAST);
        out_med[ch] <= m3_vec[ch][MED_INDEX];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      m1_valid  <= 1'b0;
      m2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s2_valid  <= s1_valid && s1_flags.emit;
      m1_valid  <= s2_valid;
      m2_valid  <= m1_valid;
      out_valid <= m2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_last  <= s1_flags.last;
      m1_last  <= s2_last;
      m2_last  <= m1_last;
      out_last <= m2_last;
    end
  end

  assign result.valid        = out_valid;
  assign result.red_median   = out_med[0];
  assign result.green_median = out_med[1];
  assign result.blue_median  = out_med[2];
  assign result.frame_end    = out_last;

endmodule
